// ===== rtl/hirt_pkg.sv =====
// Shared types and constants for the HID-over-I2C register target.
package hirt_pkg;

  localparam int DEF_BUF_DEPTH = 1024;
  localparam int DESC_BYTES    = 30;
  localparam int DESC_IW       = $clog2(DESC_BYTES);

  localparam logic [15:0] PTR_HID_DESC  = 16'h0001;
  localparam logic [15:0] PTR_RPT_DESC  = 16'h0002;
  localparam logic [15:0] PTR_IN_REPORT = 16'h0003;
  localparam logic [15:0] PTR_COMMAND   = 16'h0005;
  localparam logic [15:0] PTR_DATA      = 16'h0006;
  localparam logic [15:0] PTR_OUT_REPORT = 16'h0007;

  localparam logic [4:0] HID_LEN_LO_IDX = 5'd4;
  localparam logic [4:0] HID_LEN_HI_IDX = 5'd5;

  typedef enum logic [2:0] {
    CMD_START     = 3'd0,
    CMD_STOP      = 3'd1,
    CMD_BUS_WRITE = 3'd2,
    CMD_BUS_READ  = 3'd3,
    CMD_LOAD_IN   = 3'd4,
    CMD_LOAD_DATA = 3'd5,
    CMD_LOAD_RPT  = 3'd6,
    CMD_LOAD_HID  = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_COMMAND = 2'd1,
    EV_DATA    = 2'd2,
    EV_OUT_RPT = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    SEL_IN_REPORT = 2'd0,
    SEL_COMMAND   = 2'd1,
    SEL_DATA      = 2'd2,
    SEL_RPT_DESC  = 2'd3
  } buf_sel_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LEN_LO,
    ST_LEN_HI
  } state_t;

  typedef struct packed {
    logic              byte_we;
    logic [DESC_IW-1:0] byte_idx;
    logic [7:0]        byte_data;
    logic              len_we;
    logic [15:0]       len_bytes;
  } desc_wr_t;

endpackage

// ===== rtl/hirt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module hirt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/hirt_desc_regs.sv =====
// HID descriptor byte store with length patch port.
module hirt_desc_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  hirt_pkg::desc_wr_t              wr,
  input  logic [hirt_pkg::DESC_IW-1:0]    rd_idx,
  output logic [7:0]                      rd_data
);

  logic [7:0] desc_r [hirt_pkg::DESC_BYTES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < hirt_pkg::DESC_BYTES; i++) begin
        desc_r[i] <= 8'h00;
      end
    end else begin
      if (wr.byte_we) begin
        desc_r[wr.byte_idx] <= wr.byte_data;
      end
      if (wr.len_we) begin
        desc_r[hirt_pkg::HID_LEN_LO_IDX] <= wr.len_bytes[7:0];
        desc_r[hirt_pkg::HID_LEN_HI_IDX] <= wr.len_bytes[15:8];
      end
    end
  end

  assign rd_data = desc_r[rd_idx];

endmodule

// ===== rtl/hid_i2c_register_target.sv =====
// Top level: HID-over-I2C register target, bus and host events in, one result word out.
//
// Input channel in_*: one event word per handshake. in_tuser carries the event kind
// (start, stop, bus write, bus read, host loads), in_tdata the byte, the master
// acknowledge and the host load position, in_tlast the final byte of a host load.
// Output channel out_*: exactly one result word per input word, in order; out_tdata
// holds the byte returned by a bus read (0 otherwise), out_tuser the buffer written
// since the last start, reported on stop (0 otherwise).
// The four byte buffers share one RAM of 4 * 2**clog2(BUF_DEPTH) bytes with a
// registered read; the HID descriptor lives in flops.
// The result word is registered; in_tready is low while a bus read passes through
// ST_READ (RAM read then capture) and while a length-prefixed report load with
// in_tlast passes through ST_LEN_LO and ST_LEN_HI (the two length bytes take
// the single RAM write port one after the other).
// After reset the block sweeps all 4 * 2**clog2(BUF_DEPTH) RAM entries (4096 at
// the default) to zero, one entry per cycle; in_tready stays low meanwhile.
// The result sits in an output register; a new word is taken while it waits only
// if out_tready frees the slot in the same cycle, so a stalled receiver stalls
// the input side after one word.
module hid_i2c_register_target #(
  parameter int BUF_DEPTH = hirt_pkg::DEF_BUF_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,  // data_byte[7:0], master_ack[8], load_index[18:9], zeros
  input  logic [2:0]  in_tuser,  // cmd[2:0]
  input  logic        in_tlast,  // load_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata, // read_data[7:0]
  output logic [1:0]  out_tuser  // write_event[1:0]
);

  localparam int IW     = $clog2(BUF_DEPTH);
  localparam int RAM_AW = IW + 2;
  localparam int CW     = $clog2(BUF_DEPTH + 3);
  localparam int LW     = (CW > 11) ? CW : 11;

  hirt_pkg::state_t   state_r, state_nxt;
  logic [RAM_AW-1:0]  clr_addr_r, clr_addr_nxt;
  logic [15:0]        reg_pointer_r, reg_pointer_nxt;
  logic [CW-1:0]      write_count_r, write_count_nxt;
  logic [CW-1:0]      read_index_r, read_index_nxt;
  hirt_pkg::event_t   pending_r, pending_nxt;
  logic [CW-1:0]      rpt_len_r, rpt_len_nxt;
  logic [15:0]        len_r, len_nxt;
  hirt_pkg::buf_sel_t len_sel_r, len_sel_nxt;
  logic               rd_hit_r, rd_hit_nxt;
  logic               rd_desc_r, rd_desc_nxt;
  logic [7:0]         rd_desc_byte_r, rd_desc_byte_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_data_r, out_data_nxt;
  hirt_pkg::event_t   out_event_r, out_event_nxt;

  logic               ram_we;
  logic [RAM_AW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]         ram_wdata, ram_rdata;
  hirt_pkg::desc_wr_t desc_wr;
  logic [7:0]         desc_rdata;

  hirt_pkg::cmd_t     cmd;
  logic [7:0]         data_byte;
  logic               master_ack;
  logic [9:0]         load_index;
  logic [LW-1:0]      idx_w, pos_w, rlen_w;
  logic [CW-1:0]      wpos;
  hirt_pkg::event_t   wr_ev;
  hirt_pkg::buf_sel_t wr_sel;

  assign cmd        = hirt_pkg::cmd_t'(in_tuser);
  assign data_byte  = in_tdata[7:0];
  assign master_ack = in_tdata[8];
  assign load_index = in_tdata[18:9];
  assign idx_w      = LW'(load_index);
  assign pos_w      = idx_w + LW'(2);
  assign rlen_w     = (idx_w + LW'(1) > LW'(BUF_DEPTH)) ? LW'(BUF_DEPTH) : idx_w + LW'(1);
  assign wpos       = write_count_r - CW'(2);

  always_comb begin
    case (reg_pointer_r)
      hirt_pkg::PTR_COMMAND: begin
        wr_ev  = hirt_pkg::EV_COMMAND;
        wr_sel = hirt_pkg::SEL_COMMAND;
      end
      hirt_pkg::PTR_DATA: begin
        wr_ev  = hirt_pkg::EV_DATA;
        wr_sel = hirt_pkg::SEL_DATA;
      end
      hirt_pkg::PTR_OUT_REPORT: begin
        wr_ev  = hirt_pkg::EV_OUT_RPT;
        wr_sel = hirt_pkg::SEL_DATA;
      end
      default: begin
        wr_ev  = hirt_pkg::EV_NONE;
        wr_sel = hirt_pkg::SEL_DATA;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= hirt_pkg::ST_CLEAR;
      clr_addr_r    <= '0;
      reg_pointer_r <= '0;
      write_count_r <= '0;
      read_index_r  <= '0;
      pending_r     <= hirt_pkg::EV_NONE;
      rpt_len_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_addr_r    <= clr_addr_nxt;
      reg_pointer_r <= reg_pointer_nxt;
      write_count_r <= write_count_nxt;
      read_index_r  <= read_index_nxt;
      pending_r     <= pending_nxt;
      rpt_len_r     <= rpt_len_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r          <= len_nxt;
    len_sel_r      <= len_sel_nxt;
    rd_hit_r       <= rd_hit_nxt;
    rd_desc_r      <= rd_desc_nxt;
    rd_desc_byte_r <= rd_desc_byte_nxt;
    out_data_r     <= out_data_nxt;
    out_event_r    <= out_event_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    clr_addr_nxt     = clr_addr_r;
    reg_pointer_nxt  = reg_pointer_r;
    write_count_nxt  = write_count_r;
    read_index_nxt   = read_index_r;
    pending_nxt      = pending_r;
    rpt_len_nxt      = rpt_len_r;
    len_nxt          = len_r;
    len_sel_nxt      = len_sel_r;
    rd_hit_nxt       = rd_hit_r;
    rd_desc_nxt      = rd_desc_r;
    rd_desc_byte_nxt = rd_desc_byte_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_data_nxt     = out_data_r;
    out_event_nxt    = out_event_r;
    in_tready        = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = '0;
    ram_wdata        = 8'h00;
    ram_raddr        = '0;
    desc_wr          = '0;

    case (state_r)
      hirt_pkg::ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + RAM_AW'(1);
        if (&clr_addr_r) begin
          state_nxt = hirt_pkg::ST_IDLE;
        end
      end

      hirt_pkg::ST_IDLE: begin
        in_tready = !out_valid_r || out_tready;
        if (in_tvalid && in_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = 8'h00;
          out_event_nxt = hirt_pkg::EV_NONE;
          case (cmd)
            hirt_pkg::CMD_START: begin
              write_count_nxt = '0;
              read_index_nxt  = '0;
              pending_nxt     = hirt_pkg::EV_NONE;
            end
            hirt_pkg::CMD_STOP: begin
              out_event_nxt   = pending_r;
              write_count_nxt = '0;
              read_index_nxt  = '0;
            end
            hirt_pkg::CMD_BUS_WRITE: begin
              if (write_count_r == CW'(0)) begin
                reg_pointer_nxt = {8'h00, data_byte};
                write_count_nxt = CW'(1);
              end else if (write_count_r == CW'(1)) begin
                reg_pointer_nxt = {data_byte, reg_pointer_r[7:0]};
                write_count_nxt = CW'(2);
              end else if (wr_ev != hirt_pkg::EV_NONE) begin
                if (wpos < CW'(BUF_DEPTH) && wr_ev != hirt_pkg::EV_OUT_RPT) begin
                  ram_we    = 1'b1;
                  ram_waddr = {wr_sel, wpos[IW-1:0]};
                  ram_wdata = data_byte;
                end
                if (write_count_r < CW'(BUF_DEPTH + 2)) begin
                  write_count_nxt = write_count_r + CW'(1);
                end
                pending_nxt = wr_ev;
              end
            end
            hirt_pkg::CMD_BUS_READ: begin
              out_valid_nxt    = 1'b0;
              rd_desc_nxt      = 1'b0;
              rd_hit_nxt       = 1'b0;
              rd_desc_byte_nxt = desc_rdata;
              ram_raddr        = {hirt_pkg::SEL_IN_REPORT, read_index_r[IW-1:0]};
              case (reg_pointer_r)
                hirt_pkg::PTR_HID_DESC: begin
                  rd_desc_nxt = 1'b1;
                  rd_hit_nxt  = read_index_r < CW'(hirt_pkg::DESC_BYTES);
                end
                hirt_pkg::PTR_RPT_DESC: begin
                  ram_raddr  = {hirt_pkg::SEL_RPT_DESC, read_index_r[IW-1:0]};
                  rd_hit_nxt = read_index_r < rpt_len_r;
                end
                hirt_pkg::PTR_IN_REPORT: begin
                  rd_hit_nxt = read_index_r < CW'(BUF_DEPTH);
                end
                hirt_pkg::PTR_COMMAND: begin
                  ram_raddr  = {hirt_pkg::SEL_COMMAND, read_index_r[IW-1:0]};
                  rd_hit_nxt = read_index_r < CW'(BUF_DEPTH);
                end
                hirt_pkg::PTR_DATA: begin
                  ram_raddr  = {hirt_pkg::SEL_DATA, read_index_r[IW-1:0]};
                  rd_hit_nxt = read_index_r < CW'(BUF_DEPTH);
                end
                default: begin
                  rd_hit_nxt = 1'b0;
                end
              endcase
              if (!master_ack && read_index_r < CW'(BUF_DEPTH)) begin
                read_index_nxt = read_index_r + CW'(1);
              end
              state_nxt = hirt_pkg::ST_READ;
            end
            hirt_pkg::CMD_LOAD_IN, hirt_pkg::CMD_LOAD_DATA: begin
              len_sel_nxt = (cmd == hirt_pkg::CMD_LOAD_IN) ? hirt_pkg::SEL_IN_REPORT
                                                           : hirt_pkg::SEL_DATA;
              if (pos_w < LW'(BUF_DEPTH)) begin
                ram_we    = 1'b1;
                ram_waddr = {len_sel_nxt, pos_w[IW-1:0]};
                ram_wdata = data_byte;
              end
              if (in_tlast) begin
                len_nxt   = 16'(load_index) + 16'd1;
                state_nxt = hirt_pkg::ST_LEN_LO;
              end
            end
            hirt_pkg::CMD_LOAD_RPT: begin
              if (idx_w < LW'(BUF_DEPTH)) begin
                ram_we    = 1'b1;
                ram_waddr = {hirt_pkg::SEL_RPT_DESC, idx_w[IW-1:0]};
                ram_wdata = data_byte;
              end
              if (in_tlast) begin
                rpt_len_nxt       = CW'(rlen_w);
                desc_wr.len_we    = 1'b1;
                desc_wr.len_bytes = 16'(rlen_w);
              end
            end
            default: begin
              if (load_index < 10'(hirt_pkg::DESC_BYTES)) begin
                desc_wr.byte_we   = 1'b1;
                desc_wr.byte_idx  = load_index[hirt_pkg::DESC_IW-1:0];
                desc_wr.byte_data = data_byte;
              end
            end
          endcase
        end
      end

      hirt_pkg::ST_READ: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = !rd_hit_r ? 8'h00 : (rd_desc_r ? rd_desc_byte_r : ram_rdata);
        out_event_nxt = hirt_pkg::EV_NONE;
        state_nxt     = hirt_pkg::ST_IDLE;
      end

      hirt_pkg::ST_LEN_LO: begin
        ram_we    = 1'b1;
        ram_waddr = {len_sel_r, IW'(0)};
        ram_wdata = len_r[7:0];
        state_nxt = hirt_pkg::ST_LEN_HI;
      end

      hirt_pkg::ST_LEN_HI: begin
        ram_we    = 1'b1;
        ram_waddr = {len_sel_r, IW'(1)};
        ram_wdata = len_r[15:8];
        state_nxt = hirt_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = hirt_pkg::ST_IDLE;
      end
    endcase
  end

  hirt_ram #(
    .WIDTH (8),
    .DEPTH (1 << RAM_AW)
  ) u_buf_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hirt_desc_regs u_desc (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (desc_wr),
    .rd_idx  (read_index_r[hirt_pkg::DESC_IW-1:0]),
    .rd_data (desc_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_event_r;

endmodule

// ===== tb/hid_i2c_register_target_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the HID-over-I2C register target: directed and random traffic.
module hid_i2c_register_target_tb;

  localparam int BUF = hirt_pkg::DEF_BUF_DEPTH;
  localparam int DESC_N = hirt_pkg::DESC_BYTES;
  localparam int STALL_LIMIT = 20000;
  localparam logic [15:0] PTR_UNUSED = 16'h0004;

  typedef struct {
    hirt_pkg::cmd_t kind;
    logic [7:0]     value;
    logic           ack;
    logic [9:0]     pos;
    logic           last;
    bit             drain;
  } i2c_word_t;

  typedef struct {
    logic [7:0]       rd;
    hirt_pkg::event_t ev;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // data_byte[7:0], master_ack[8], load_index[18:9], zeros
  logic [2:0]  in_tuser = '0;   // cmd[2:0]
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // read_data[7:0]
  logic [1:0]  out_tuser;       // write_event[1:0]

  hid_i2c_register_target u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // target state as seen by the bus and the host
  logic [15:0]      tgt_ptr;
  int unsigned      tgt_wr_cnt;
  int unsigned      tgt_rd_idx;
  int unsigned      tgt_rpt_len;
  hirt_pkg::event_t tgt_pending;
  logic [7:0]       tgt_in_rpt [BUF];
  logic [7:0]       tgt_cmd_buf [BUF];
  logic [7:0]       tgt_data_buf [BUF];
  logic [7:0]       tgt_rpt_desc [BUF];
  logic [7:0]       tgt_hid [DESC_N];

  i2c_word_t word_q[$];
  reply_t    reply_q[$];
  int        words_queued = 0;
  int        kind_seen[8];
  int        results_seen = 0;
  int        mismatches = 0;
  int        idle_cycles = 0;

  int        send_gap, send_burst = 0;
  int        recv_gap, recv_burst = 0;
  logic      holding, next_valid;
  reply_t    sent_r, chk_r;

  function automatic void clear_target();
    tgt_ptr = '0;
    tgt_wr_cnt = 0;
    tgt_rd_idx = 0;
    tgt_rpt_len = 0;
    tgt_pending = hirt_pkg::EV_NONE;
    for (int i = 0; i < BUF; i++) begin
      tgt_in_rpt[i] = '0;
      tgt_cmd_buf[i] = '0;
      tgt_data_buf[i] = '0;
      tgt_rpt_desc[i] = '0;
    end
    for (int i = 0; i < DESC_N; i++) tgt_hid[i] = '0;
  endfunction

  function automatic logic [7:0] read_byte();
    case (tgt_ptr)
      hirt_pkg::PTR_HID_DESC:
        return (tgt_rd_idx < DESC_N) ? tgt_hid[tgt_rd_idx] : 8'h00;
      hirt_pkg::PTR_RPT_DESC:
        return (tgt_rd_idx < tgt_rpt_len && tgt_rd_idx < BUF) ?
               tgt_rpt_desc[tgt_rd_idx] : 8'h00;
      hirt_pkg::PTR_IN_REPORT:
        return (tgt_rd_idx < BUF) ? tgt_in_rpt[tgt_rd_idx] : 8'h00;
      hirt_pkg::PTR_COMMAND:
        return (tgt_rd_idx < BUF) ? tgt_cmd_buf[tgt_rd_idx] : 8'h00;
      hirt_pkg::PTR_DATA:
        return (tgt_rd_idx < BUF) ? tgt_data_buf[tgt_rd_idx] : 8'h00;
      default:
        return 8'h00;
    endcase
  endfunction

  function automatic void bus_write(logic [7:0] b);
    hirt_pkg::event_t wr_ev;
    int unsigned      slot;
    if (tgt_wr_cnt == 0) begin
      tgt_ptr = {8'h00, b};
      tgt_wr_cnt = 1;
    end else if (tgt_wr_cnt == 1) begin
      tgt_ptr[15:8] = b;
      tgt_wr_cnt = 2;
    end else begin
      case (tgt_ptr)
        hirt_pkg::PTR_COMMAND:    wr_ev = hirt_pkg::EV_COMMAND;
        hirt_pkg::PTR_DATA:       wr_ev = hirt_pkg::EV_DATA;
        hirt_pkg::PTR_OUT_REPORT: wr_ev = hirt_pkg::EV_OUT_RPT;
        default:                  wr_ev = hirt_pkg::EV_NONE;
      endcase
      if (wr_ev != hirt_pkg::EV_NONE) begin
        slot = tgt_wr_cnt - 2;
        if (slot < BUF) begin
          if (wr_ev == hirt_pkg::EV_COMMAND) tgt_cmd_buf[slot] = b;
          else if (wr_ev == hirt_pkg::EV_DATA) tgt_data_buf[slot] = b;
        end
        if (tgt_wr_cnt < BUF + 2) tgt_wr_cnt++;
        tgt_pending = wr_ev;
      end
    end
  endfunction

  // input and data reports carry a two-byte length ahead of the payload
  function automatic void load_prefixed(bit to_data, int unsigned at, logic [7:0] b,
                                        logic last);
    int unsigned len;
    len = at + 1;
    if (at + 2 < BUF) begin
      if (to_data) tgt_data_buf[at + 2] = b;
      else tgt_in_rpt[at + 2] = b;
    end
    if (last) begin
      if (to_data) begin
        tgt_data_buf[0] = 8'(len);
        tgt_data_buf[1] = 8'(len >> 8);
      end else begin
        tgt_in_rpt[0] = 8'(len);
        tgt_in_rpt[1] = 8'(len >> 8);
      end
    end
  endfunction

  function automatic reply_t target_step(i2c_word_t w);
    reply_t      r;
    int unsigned len;
    r.rd = 8'h00;
    r.ev = hirt_pkg::EV_NONE;
    case (w.kind)
      hirt_pkg::CMD_START: begin
        tgt_wr_cnt = 0;
        tgt_rd_idx = 0;
        tgt_pending = hirt_pkg::EV_NONE;
      end
      hirt_pkg::CMD_STOP: begin
        r.ev = tgt_pending;
        tgt_wr_cnt = 0;
        tgt_rd_idx = 0;
      end
      hirt_pkg::CMD_BUS_WRITE: bus_write(w.value);
      hirt_pkg::CMD_BUS_READ: begin
        r.rd = read_byte();
        if (!w.ack && tgt_rd_idx < BUF) tgt_rd_idx++;
      end
      hirt_pkg::CMD_LOAD_IN:   load_prefixed(1'b0, w.pos, w.value, w.last);
      hirt_pkg::CMD_LOAD_DATA: load_prefixed(1'b1, w.pos, w.value, w.last);
      hirt_pkg::CMD_LOAD_RPT: begin
        if (w.pos < BUF) tgt_rpt_desc[w.pos] = w.value;
        if (w.last) begin
          len = (w.pos + 1 > BUF) ? BUF : w.pos + 1;
          tgt_rpt_len = len;
          tgt_hid[hirt_pkg::HID_LEN_LO_IDX] = 8'(len);
          tgt_hid[hirt_pkg::HID_LEN_HI_IDX] = 8'(len >> 8);
        end
      end
      default: begin
        if (w.pos < DESC_N) tgt_hid[w.pos] = w.value;
      end
    endcase
    return r;
  endfunction

  // mostly back to back or short gaps, a few long ones, occasional back-to-back bursts
  function automatic int pick_delay(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_word(hirt_pkg::cmd_t kind, logic [7:0] value, logic ack,
                                    int pos, logic last);
    i2c_word_t w;
    w.kind = kind;
    w.value = value;
    w.ack = ack;
    w.pos = 10'(pos);
    w.last = last;
    w.drain = 1'b0;
    word_q.push_back(w);
    words_queued++;
  endfunction

  function automatic void push_drain();
    i2c_word_t w;
    w.kind = hirt_pkg::CMD_START;
    w.value = '0;
    w.ack = 1'b0;
    w.pos = '0;
    w.last = 1'b0;
    w.drain = 1'b1;
    word_q.push_back(w);
  endfunction

  function automatic void write_txn(logic [15:0] ptr, int n);
    push_word(hirt_pkg::CMD_START, 8'($urandom), 1'($urandom), $urandom_range(0, 1023),
              1'($urandom));
    push_word(hirt_pkg::CMD_BUS_WRITE, ptr[7:0], 1'($urandom), 0, 1'b0);
    push_word(hirt_pkg::CMD_BUS_WRITE, ptr[15:8], 1'($urandom), 0, 1'b0);
    for (int i = 0; i < n; i++)
      push_word(hirt_pkg::CMD_BUS_WRITE, 8'($urandom), 1'($urandom),
                $urandom_range(0, 1023), 1'b0);
    push_word(hirt_pkg::CMD_STOP, 8'($urandom), 1'($urandom), 0, 1'($urandom));
  endfunction

  function automatic void read_txn(logic [15:0] ptr, int n, bit restart, bit steady);
    push_word(hirt_pkg::CMD_START, 8'h00, 1'b0, 0, 1'b0);
    push_word(hirt_pkg::CMD_BUS_WRITE, ptr[7:0], 1'b0, 0, 1'b0);
    push_word(hirt_pkg::CMD_BUS_WRITE, ptr[15:8], 1'b0, 0, 1'b0);
    if (restart) push_word(hirt_pkg::CMD_START, 8'($urandom), 1'($urandom), 0, 1'b0);
    for (int i = 0; i < n; i++)
      push_word(hirt_pkg::CMD_BUS_READ, 8'($urandom),
                steady ? 1'b0 : ($urandom_range(0, 3) == 0),
                $urandom_range(0, 1023), 1'($urandom));
    push_word(hirt_pkg::CMD_STOP, 8'h00, 1'b0, 0, 1'b0);
  endfunction

  function automatic void host_load(hirt_pkg::cmd_t kind, int first, int n);
    for (int i = 0; i < n; i++)
      push_word(kind, 8'($urandom), 1'($urandom), first + i, i == n - 1);
  endfunction

  function automatic logic [15:0] pick_ptr();
    case ($urandom_range(0, 11))
      0:       return hirt_pkg::PTR_HID_DESC;
      1:       return hirt_pkg::PTR_RPT_DESC;
      2, 3:    return hirt_pkg::PTR_IN_REPORT;
      4, 5:    return hirt_pkg::PTR_COMMAND;
      6, 7:    return hirt_pkg::PTR_DATA;
      8:       return hirt_pkg::PTR_OUT_REPORT;
      9:       return PTR_UNUSED;
      10:      return {8'h00, 8'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void random_traffic();
    int n;
    int first;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4:
        write_txn(pick_ptr(), $urandom_range(0, 8));
      5, 6, 7, 8, 9, 10:
        read_txn(pick_ptr(), $urandom_range(1, 12), 1'($urandom), 1'b0);
      11, 12: begin
        n = $urandom_range(1, 8);
        first = ($urandom_range(0, 4) == 0) ? $urandom_range(1014, 1024 - n) : 0;
        host_load(($urandom_range(0, 1) == 0) ? hirt_pkg::CMD_LOAD_IN
                                              : hirt_pkg::CMD_LOAD_DATA, first, n);
      end
      13:
        host_load(hirt_pkg::CMD_LOAD_RPT,
                  ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1000) : 0,
                  $urandom_range(1, 16));
      14:
        host_load(hirt_pkg::CMD_LOAD_HID, $urandom_range(0, 8), $urandom_range(1, 26));
      15, 16: begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
          push_word(hirt_pkg::cmd_t'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                    $urandom_range(0, 1023), 1'($urandom));
      end
      17: begin
        push_word(hirt_pkg::CMD_START, 8'h00, 1'b0, 0, 1'b0);
        push_word(hirt_pkg::CMD_BUS_WRITE, 8'($urandom), 1'b0, 0, 1'b0);
        push_word(hirt_pkg::CMD_STOP, 8'h00, 1'b0, 0, 1'b0);
      end
      18: begin
        push_word(hirt_pkg::CMD_BUS_WRITE, 8'($urandom), 1'b0, 0, 1'b0);
        push_word(hirt_pkg::CMD_BUS_WRITE, 8'($urandom), 1'b0, 0, 1'b0);
        push_word(hirt_pkg::CMD_BUS_READ, 8'h00, 1'($urandom), 0, 1'b0);
        push_word(hirt_pkg::CMD_STOP, 8'h00, 1'b0, 0, 1'b0);
        push_word(hirt_pkg::CMD_STOP, 8'h00, 1'b0, 0, 1'b0);
      end
      default:
        push_drain();
    endcase
  endfunction

  // sender: one word in flight, next one launched after its gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        sent_r = target_step(word_q[0]);
        reply_q.push_back(sent_r);
        kind_seen[word_q[0].kind]++;
        void'(word_q.pop_front());
        holding = 1'b0;
      end else begin
        holding = in_tvalid;
      end
      if (!holding) begin
        next_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (word_q.size() > 0 && word_q[0].drain) begin
          if (reply_q.size() == 0) void'(word_q.pop_front());
        end else if (word_q.size() > 0) begin
          next_valid = 1'b1;
          in_tdata <= {5'b0, word_q[0].pos, word_q[0].ack, word_q[0].value};
          in_tuser <= word_q[0].kind;
          in_tlast <= word_q[0].last;
          send_gap = pick_delay(send_burst);
        end
        in_tvalid <= next_valid;
      end
    end
  end

  // receiver: check each result word against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (reply_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result word data=%02h event=%0d", $realtime,
                     out_tdata, out_tuser);
        end else begin
          chk_r = reply_q.pop_front();
          if (out_tdata !== chk_r.rd || out_tuser !== chk_r.ev) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result %0d mismatch: data exp %02h got %02h, event exp %0d got %0d",
                       $realtime, results_seen, chk_r.rd, out_tdata, chk_r.ev, out_tuser);
          end
        end
        recv_gap = pick_delay(recv_burst);
      end else if (recv_gap > 0) begin
        recv_gap--;
      end
      out_tready <= (recv_gap == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("No handshake for %0d cycles, %0d words still queued, %0d results owed",
               idle_cycles, word_q.size(), reply_q.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) kind_seen[i] = 0;
    clear_target();

    // directed: edges of every field, each command, descriptor and length corners
    push_word(hirt_pkg::CMD_START, 8'h00, 1'b0, 0, 1'b0);
    push_word(hirt_pkg::CMD_STOP, 8'hFF, 1'b1, 1023, 1'b1);
    push_word(hirt_pkg::CMD_LOAD_HID, 8'hFF, 1'b1, 0, 1'b1);
    push_word(hirt_pkg::CMD_LOAD_HID, 8'hA5, 1'b0, 29, 1'b0);
    push_word(hirt_pkg::CMD_LOAD_HID, 8'h5A, 1'b0, 30, 1'b0);
    push_word(hirt_pkg::CMD_LOAD_RPT, 8'h81, 1'b0, 1023, 1'b1);
    push_word(hirt_pkg::CMD_LOAD_IN, 8'h7E, 1'b1, 1023, 1'b1);
    push_word(hirt_pkg::CMD_LOAD_DATA, 8'hC3, 1'b0, 1021, 1'b0);
    push_word(hirt_pkg::CMD_LOAD_DATA, 8'h00, 1'b0, 0, 1'b1);
    push_word(hirt_pkg::CMD_START, 8'h00, 1'b0, 0, 1'b0);
    push_word(hirt_pkg::CMD_BUS_WRITE, hirt_pkg::PTR_COMMAND[7:0], 1'b0, 0, 1'b0);
    push_word(hirt_pkg::CMD_BUS_WRITE, hirt_pkg::PTR_COMMAND[15:8], 1'b0, 0, 1'b0);
    push_word(hirt_pkg::CMD_BUS_WRITE, 8'hFF, 1'b0, 0, 1'b0);
    push_word(hirt_pkg::CMD_STOP, 8'h00, 1'b0, 0, 1'b0);
    push_word(hirt_pkg::CMD_STOP, 8'h00, 1'b0, 0, 1'b0);
    read_txn(hirt_pkg::PTR_HID_DESC, 6, 1'b1, 1'b0);
    write_txn(16'h1234, 1);
    write_txn(hirt_pkg::PTR_OUT_REPORT, 1);
    read_txn(16'hFFFF, 2, 1'b0, 1'b1);

    // descriptor read past its end, report descriptor read
    push_drain();
    read_txn(hirt_pkg::PTR_HID_DESC, DESC_N + 4, 1'b1, 1'b1);
    read_txn(hirt_pkg::PTR_RPT_DESC, 8, 1'b1, 1'b1);
    push_drain();

    while (words_queued < 650) random_traffic();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (word_q.size() != 0) @(negedge clk);
    while (reply_q.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d event words (%0d bus reads, %0d bus writes, %0d stops, %0d host loads)",
             words_queued, kind_seen[hirt_pkg::CMD_BUS_READ],
             kind_seen[hirt_pkg::CMD_BUS_WRITE], kind_seen[hirt_pkg::CMD_STOP],
             kind_seen[hirt_pkg::CMD_LOAD_IN] + kind_seen[hirt_pkg::CMD_LOAD_DATA] +
             kind_seen[hirt_pkg::CMD_LOAD_RPT] + kind_seen[hirt_pkg::CMD_LOAD_HID]);
    $display("Checked %0d result words, %0d mismatches, with random stalls on both sides",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/hirt_pkg.sv
rtl/hirt_ram.sv
rtl/hirt_desc_regs.sv
rtl/hid_i2c_register_target.sv
tb/hid_i2c_register_target_tb.sv
